/* src/caaf_pkg.sv */
// shared types for the arithmetic alu: function codes, decimal adjust constants and the input and result words
// no dependencies; imported by caaf_alu, cpu_alu_arith_flags and its testbench
package caaf_pkg;

    typedef enum logic [3:0] {
        FUNC_ADD    = 4'd0,
        FUNC_ADC    = 4'd1,
        FUNC_SUB    = 4'd2,
        FUNC_SBC    = 4'd3,
        FUNC_INC8   = 4'd4,
        FUNC_DEC8   = 4'd5,
        FUNC_DAA    = 4'd6,
        FUNC_ADD16  = 4'd7,
        FUNC_ADD_SP = 4'd8,
        FUNC_INC16  = 4'd9,
        FUNC_DEC16  = 4'd10
    } t_func;

    localparam logic [7:0] DAA_LOW_ADJ  = 8'h06;
    localparam logic [7:0] DAA_HIGH_ADJ = 8'h60;
    localparam logic [7:0] DAA_HIGH_MAX = 8'h99;
    localparam logic [3:0] BCD_DIGIT_MAX = 4'd9;

    typedef struct packed {
        t_func       func;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic        zero_in;
        logic        subtract_in;
        logic        half_in;
        logic        carry_in;
    } t_in_word;

    typedef struct packed {
        logic [15:0] result;
        logic        zero_out;
        logic        subtract_out;
        logic        half_out;
        logic        carry_out;
    } t_out_word;

    function automatic logic is_byte_op(t_func f);
        return (f == FUNC_ADD) || (f == FUNC_ADC) || (f == FUNC_SUB) || (f == FUNC_SBC) ||
               (f == FUNC_INC8) || (f == FUNC_DEC8) || (f == FUNC_DAA);
    endfunction

endpackage

/* src/cpu_alu_arith_flags.sv */
// Arithmetic ALU of an 8-bit console CPU, top level.
// Holds the input register, the ALU datapath and the result register.
//
// Input channel: i_valid / o_ready carry one operation word (t_in_word):
// function code, two 16-bit operands and the current Z, N, H, C flags.
// Output channel: o_valid / i_ready carry one result word (t_out_word):
// 16-bit result (upper byte zero for 8-bit operations) and the new flags.
// Every operation gives exactly one result word, in order.
//
// Each accepted word passes the input register, then the result register fed
// by one pass through the adders and flag logic, before o_valid rises.
// Throughput: one word per cycle while the receiver takes results.
// When the receiver stalls, the result register holds its word and the input
// register takes one more; o_ready then falls until the result is taken.
// o_ready depends combinationally on i_ready through this two-register chain.
// Reset (i_rst_n low, synchronous) empties both registers; their data words are not cleared.
// depends on caaf_pkg and caaf_alu
module cpu_alu_arith_flags (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  caaf_pkg::t_in_word  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output caaf_pkg::t_out_word o_data
);
    import caaf_pkg::*;

    logic      r_in_valid;
    logic      n_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_word r_out;
    t_out_word alu_word;
    logic      advance;

    caaf_alu u_alu (
        .i_word (r_in),
        .o_word (alu_word)
    );

    // result stage can take a new word when empty or being drained
    assign advance = !r_out_valid || i_ready;
    assign o_ready = !r_in_valid || advance;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = r_in_valid;
        end
        if (o_ready) begin
            n_in_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_data;
        end
        if (advance && r_in_valid) begin
            r_out <= alu_word;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready && r_in_valid) |-> !o_ready)
        else $error("input taken while both stages full");

    a_word_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance) |=> o_valid)
        else $error("word lost between stages");

    a_byte_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && is_byte_op(r_in.func)) |=> (o_data.result[15:8] == 8'd0))
        else $error("8-bit result has non-zero upper byte");

    a_sp_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && (r_in.func == FUNC_ADD_SP))
            |=> (!o_data.zero_out && !o_data.subtract_out))
        else $error("sp offset add left Z or N set");

endmodule

/* src/caaf_alu.sv */
// combinational datapath of the arithmetic alu: adders, decimal adjust and flag logic
// depends on caaf_pkg
module caaf_alu (
    input  caaf_pkg::t_in_word  i_word,
    output caaf_pkg::t_out_word o_word
);
    import caaf_pkg::*;

    logic [7:0]  a8;
    logic [7:0]  b8;
    logic        cin;
    logic [8:0]  sum8;
    logic [4:0]  sum4;
    logic [8:0]  dif8;
    logic [4:0]  dif4;
    logic [7:0]  daa_val;
    logic        daa_carry;
    logic [16:0] sum16;
    logic [12:0] sum12;
    logic [15:0] offset;
    logic [8:0]  sp_low;
    logic [4:0]  sp_nib;

    always_comb begin
        a8  = i_word.operand_a[7:0];
        b8  = i_word.operand_b[7:0];
        // carry/borrow only joins in for the with-carry forms
        cin = ((i_word.func == FUNC_ADC) || (i_word.func == FUNC_SBC)) && i_word.carry_in;

        sum8 = {1'b0, a8} + {1'b0, b8} + {8'd0, cin};
        sum4 = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cin};
        dif8 = {1'b0, a8} - {1'b0, b8} - {8'd0, cin};
        dif4 = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cin};

        // decimal adjust, thresholds taken from the unadjusted accumulator
        daa_val   = a8;
        daa_carry = i_word.carry_in;
        if (!i_word.subtract_in) begin
            if (i_word.carry_in || (a8 > DAA_HIGH_MAX)) begin
                daa_val   = daa_val + DAA_HIGH_ADJ;
                daa_carry = 1'b1;
            end
            if (i_word.half_in || (a8[3:0] > BCD_DIGIT_MAX)) begin
                daa_val = daa_val + DAA_LOW_ADJ;
            end
        end else begin
            if (i_word.carry_in) begin
                daa_val = daa_val - DAA_HIGH_ADJ;
            end
            if (i_word.half_in) begin
                daa_val = daa_val - DAA_LOW_ADJ;
            end
        end

        sum16  = {1'b0, i_word.operand_a} + {1'b0, i_word.operand_b};
        sum12  = {1'b0, i_word.operand_a[11:0]} + {1'b0, i_word.operand_b[11:0]};
        offset = {{8{b8[7]}}, b8};
        sp_low = {1'b0, i_word.operand_a[7:0]} + {1'b0, b8};
        sp_nib = {1'b0, i_word.operand_a[3:0]} + {1'b0, b8[3:0]};

        o_word.result       = '0;
        o_word.zero_out     = i_word.zero_in;
        o_word.subtract_out = i_word.subtract_in;
        o_word.half_out     = i_word.half_in;
        o_word.carry_out    = i_word.carry_in;

        unique case (i_word.func)
            FUNC_ADD, FUNC_ADC: begin
                o_word.result       = {8'd0, sum8[7:0]};
                o_word.zero_out     = (sum8[7:0] == 8'd0);
                o_word.subtract_out = 1'b0;
                o_word.half_out     = sum4[4];
                o_word.carry_out    = sum8[8];
            end
            FUNC_SUB, FUNC_SBC: begin
                o_word.result       = {8'd0, dif8[7:0]};
                o_word.zero_out     = (dif8[7:0] == 8'd0);
                o_word.subtract_out = 1'b1;
                o_word.half_out     = dif4[4];
                o_word.carry_out    = dif8[8];
            end
            FUNC_INC8: begin
                o_word.result       = {8'd0, a8 + 8'd1};
                o_word.zero_out     = (a8 == 8'hff);
                o_word.subtract_out = 1'b0;
                o_word.half_out     = (a8[3:0] == 4'hf);
            end
            FUNC_DEC8: begin
                o_word.result       = {8'd0, a8 - 8'd1};
                o_word.zero_out     = (a8 == 8'h01);
                o_word.subtract_out = 1'b1;
                o_word.half_out     = (a8[3:0] == 4'h0);
            end
            FUNC_DAA: begin
                o_word.result    = {8'd0, daa_val};
                o_word.zero_out  = (daa_val == 8'd0);
                o_word.half_out  = 1'b0;
                o_word.carry_out = daa_carry;
            end
            FUNC_ADD16: begin
                o_word.result       = sum16[15:0];
                o_word.subtract_out = 1'b0;
                o_word.half_out     = sum12[12];
                o_word.carry_out    = sum16[16];
            end
            FUNC_ADD_SP: begin
                o_word.result       = i_word.operand_a + offset;
                o_word.zero_out     = 1'b0;
                o_word.subtract_out = 1'b0;
                o_word.half_out     = sp_nib[4];
                o_word.carry_out    = sp_low[8];
            end
            FUNC_INC16: begin
                o_word.result = i_word.operand_a + 16'd1;
            end
            FUNC_DEC16: begin
                o_word.result = i_word.operand_a - 16'd1;
            end
            default: begin
                // unused codes: zero result, flags pass
                o_word.result = '0;
            end
        endcase
    end

endmodule

/* test/cpu_alu_arith_flags_test.sv */
// self-checking testbench for cpu_alu_arith_flags: directed corner words then random traffic
// with random idling on both channels, every result word checked against a local predictor
// depends on caaf_pkg and the cpu_alu_arith_flags top level
module cpu_alu_arith_flags_test;
    import caaf_pkg::*;

    localparam logic [3:0] FUNC_UNUSED_LO = 4'd11;
    localparam logic [3:0] FUNC_UNUSED_HI = 4'd15;
    localparam int RANDOM_WORDS = 1500;

    class arith_flag_checker;
        t_out_word pending_results[$];
        int        errors;
        int        words_checked;
        int        op_count[16];

        function new();
            errors = 0;
            words_checked = 0;
            foreach (op_count[i]) op_count[i] = 0;
        endfunction

        // expected result word for one operation word
        function t_out_word arith_outcome(t_in_word w);
            t_out_word   r;
            logic [7:0]  a8;
            logic [7:0]  b8;
            logic [7:0]  acc;
            logic [8:0]  s9;
            logic [4:0]  s5;
            logic [16:0] s17;
            logic [12:0] s12;
            logic        cin;
            a8 = w.operand_a[7:0];
            b8 = w.operand_b[7:0];
            r.result = '0;
            r.zero_out = w.zero_in;
            r.subtract_out = w.subtract_in;
            r.half_out = w.half_in;
            r.carry_out = w.carry_in;
            case (w.func)
                FUNC_ADD, FUNC_ADC: begin
                    cin = (w.func == FUNC_ADC) && w.carry_in;
                    s9 = {1'b0, a8} + {1'b0, b8} + {8'd0, cin};
                    s5 = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cin};
                    r.result = {8'h00, s9[7:0]};
                    r.zero_out = (s9[7:0] == 8'h00);
                    r.subtract_out = 1'b0;
                    r.half_out = s5[4];
                    r.carry_out = s9[8];
                end
                FUNC_SUB, FUNC_SBC: begin
                    cin = (w.func == FUNC_SBC) && w.carry_in;
                    // borrow shows up as the sign bit of the widened difference
                    s9 = {1'b0, a8} - {1'b0, b8} - {8'd0, cin};
                    s5 = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cin};
                    r.result = {8'h00, s9[7:0]};
                    r.zero_out = (s9[7:0] == 8'h00);
                    r.subtract_out = 1'b1;
                    r.half_out = s5[4];
                    r.carry_out = s9[8];
                end
                FUNC_INC8: begin
                    acc = a8 + 8'd1;
                    r.result = {8'h00, acc};
                    r.zero_out = (acc == 8'h00);
                    r.subtract_out = 1'b0;
                    r.half_out = (a8[3:0] == 4'hf);
                end
                FUNC_DEC8: begin
                    acc = a8 - 8'd1;
                    r.result = {8'h00, acc};
                    r.zero_out = (acc == 8'h00);
                    r.subtract_out = 1'b1;
                    r.half_out = (a8[3:0] == 4'h0);
                end
                FUNC_DAA: begin
                    acc = a8;
                    if (!w.subtract_in) begin
                        if (w.carry_in || a8 > DAA_HIGH_MAX) begin
                            acc = acc + DAA_HIGH_ADJ;
                            r.carry_out = 1'b1;
                        end
                        if (w.half_in || a8[3:0] > BCD_DIGIT_MAX) acc = acc + DAA_LOW_ADJ;
                    end else begin
                        if (w.carry_in) acc = acc - DAA_HIGH_ADJ;
                        if (w.half_in) acc = acc - DAA_LOW_ADJ;
                    end
                    r.result = {8'h00, acc};
                    r.zero_out = (acc == 8'h00);
                    r.half_out = 1'b0;
                end
                FUNC_ADD16: begin
                    s17 = {1'b0, w.operand_a} + {1'b0, w.operand_b};
                    s12 = {1'b0, w.operand_a[11:0]} + {1'b0, w.operand_b[11:0]};
                    r.result = s17[15:0];
                    r.subtract_out = 1'b0;
                    r.half_out = s12[12];
                    r.carry_out = s17[16];
                end
                FUNC_ADD_SP: begin
                    // flags come from the unsigned low-byte add, the sum from the signed offset
                    s5 = {1'b0, w.operand_a[3:0]} + {1'b0, b8[3:0]};
                    s9 = {1'b0, w.operand_a[7:0]} + {1'b0, b8};
                    r.result = w.operand_a + {{8{b8[7]}}, b8};
                    r.zero_out = 1'b0;
                    r.subtract_out = 1'b0;
                    r.half_out = s5[4];
                    r.carry_out = s9[8];
                end
                FUNC_INC16: r.result = w.operand_a + 16'd1;
                FUNC_DEC16: r.result = w.operand_a - 16'd1;
                default: r.result = '0;
            endcase
            return r;
        endfunction

        function void note_operation(t_in_word w);
            op_count[w.func]++;
            pending_results.push_back(arith_outcome(w));
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $error("%s: expected %h, got %h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_out_word got);
            t_out_word want;
            if (pending_results.size() == 0) begin
                $error("result word %h arrived with nothing outstanding", got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            words_checked++;
            compare_field("result", want.result, got.result);
            compare_field("zero_out", 16'(want.zero_out), 16'(got.zero_out));
            compare_field("subtract_out", 16'(want.subtract_out), 16'(got.subtract_out));
            compare_field("half_out", 16'(want.half_out), 16'(got.half_out));
            compare_field("carry_out", 16'(want.carry_out), 16'(got.carry_out));
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_word  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_word o_data;

    arith_flag_checker sb;
    bit                quiet;

    cpu_alu_arith_flags uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver side: stalls about one cycle in five outside the quiet stretch
    always @(posedge i_clk) begin
        i_ready <= quiet || ($urandom_range(99) >= 20);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) sb.note_operation(i_data);
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_data);
    end

    function automatic t_in_word make_word(logic [3:0] code, logic [15:0] a, logic [15:0] b,
                                           logic [3:0] znhc);
        t_in_word w;
        w.func = t_func'(code);
        w.operand_a = a;
        w.operand_b = b;
        {w.zero_in, w.subtract_in, w.half_in, w.carry_in} = znhc;
        return w;
    endfunction

    function automatic logic [15:0] pick_operand();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return {4'($urandom), 4'hf, 4'($urandom), 4'hf};
            3: return {4'($urandom), 4'h0, 4'($urandom), 4'h0};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_word random_word();
        t_in_word   pre;
        t_out_word  post;
        logic [3:0] code;
        logic [3:0] pre_code;
        logic [7:0] x;
        logic [7:0] y;
        if ($urandom_range(9) == 0) code = 4'($urandom_range(FUNC_UNUSED_HI, FUNC_UNUSED_LO));
        else code = 4'($urandom_range(FUNC_DEC16, FUNC_ADD));
        // most decimal adjusts follow a real bcd add or subtract, flags included
        if (code == FUNC_DAA && $urandom_range(9) < 7) begin
            x = {4'($urandom_range(9)), 4'($urandom_range(9))};
            y = {4'($urandom_range(9)), 4'($urandom_range(9))};
            pre_code = 4'($urandom_range(FUNC_SBC, FUNC_ADD));
            pre = make_word(pre_code, {8'($urandom), x}, {8'($urandom), y}, 4'($urandom));
            post = sb.arith_outcome(pre);
            return make_word(FUNC_DAA, {8'($urandom), post.result[7:0]}, 16'($urandom),
                             {post.zero_out, post.subtract_out, post.half_out,
                              post.carry_out});
        end
        return make_word(code, pick_operand(), pick_operand(), 4'($urandom));
    endfunction

    // leaves valid high on return so back-to-back words need no re-raise
    task automatic send_word(t_in_word w);
        int gap;
        gap = (!quiet && $urandom_range(99) < 20) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= w;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        int codes_seen;
        sb = new();
        quiet = 1'b0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corner words; upper bytes are set on several byte ops to show they are ignored
        send_word(make_word(FUNC_ADD,    16'hab01, 16'hcdff, 4'b0000));
        send_word(make_word(FUNC_ADD,    16'h0000, 16'h0000, 4'b0111));
        send_word(make_word(FUNC_ADC,    16'hffff, 16'hffff, 4'b0001));
        send_word(make_word(FUNC_ADC,    16'h000f, 16'h000f, 4'b1111));
        send_word(make_word(FUNC_SUB,    16'h0000, 16'h0001, 4'b0000));
        send_word(make_word(FUNC_SUB,    16'h5a42, 16'h3c42, 4'b0001));
        send_word(make_word(FUNC_SBC,    16'h0000, 16'h00ff, 4'b0001));
        send_word(make_word(FUNC_SBC,    16'h0010, 16'h000f, 4'b0001));
        send_word(make_word(FUNC_INC8,   16'h12ff, 16'hffff, 4'b0001));
        send_word(make_word(FUNC_INC8,   16'h000f, 16'h0000, 4'b1110));
        send_word(make_word(FUNC_DEC8,   16'hff00, 16'h0000, 4'b0000));
        send_word(make_word(FUNC_DEC8,   16'h0001, 16'h0000, 4'b0001));
        send_word(make_word(FUNC_DAA,    16'h009a, 16'h0000, 4'b0000));
        send_word(make_word(FUNC_DAA,    16'h0000, 16'h0000, 4'b0011));
        send_word(make_word(FUNC_DAA,    16'h0000, 16'h0000, 4'b0111));
        send_word(make_word(FUNC_DAA,    16'hff66, 16'h0000, 4'b1110));
        send_word(make_word(FUNC_ADD16,  16'hffff, 16'h0001, 4'b1000));
        send_word(make_word(FUNC_ADD16,  16'h0fff, 16'h0001, 4'b0110));
        send_word(make_word(FUNC_ADD_SP, 16'hffff, 16'hff80, 4'b1111));
        send_word(make_word(FUNC_ADD_SP, 16'h00ff, 16'h007f, 4'b0000));
        send_word(make_word(FUNC_INC16,  16'hffff, 16'h0000, 4'b1010));
        send_word(make_word(FUNC_DEC16,  16'h0000, 16'h0000, 4'b0101));
        send_word(make_word(FUNC_UNUSED_LO, 16'hffff, 16'hffff, 4'b1010));
        send_word(make_word(FUNC_UNUSED_HI, 16'h1234, 16'h5678, 4'b0101));
        drain_results();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            quiet = (n >= 500 && n < 800);
            // hold the sender back once until the pipeline has emptied
            if (n == 1000) drain_results();
            send_word(random_word());
        end
        drain_results();
        repeat (10) @(posedge i_clk);

        codes_seen = 0;
        foreach (sb.op_count[i]) if (sb.op_count[i] != 0) codes_seen++;
        $display("checked %0d result words over %0d of 16 function codes", sb.words_checked,
                 codes_seen);
        $display("random idling on both channels, one stall-free stretch, one full drain");
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
